[sv/merkle_root_double_sha256_macros.svh]
// ----------------------------------------------------------------------------
// merkle root assertion macros
// shared clocked assertion forms for the merkle root block
// ----------------------------------------------------------------------------
`ifndef MERKLE_ROOT_DOUBLE_SHA256_MACROS_SVH
`define MERKLE_ROOT_DOUBLE_SHA256_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define MRD_ASSERT_IMP(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) else $error(msg);

`endif

[sv/mrdsha_pkg.sv]
// ----------------------------------------------------------------------------
// merkle root package
// sha-256 constants and the control types shared by the core and the top level
// ----------------------------------------------------------------------------
package mrdsha_pkg;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] PAD_WORD   = 32'h80000000;
   localparam logic [31:0] LEN_BLOCK  = 32'd512;
   localparam logic [31:0] LEN_DIGEST = 32'd256;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic iv_load;  // chaining value <= iv
      logic push;     // shift one 64-bit store word into the window
      logic pad_msg;  // window <= padding block of a 64-byte message
      logic pad_dig;  // window <= digest plus padding, chaining value <= iv
      logic start;    // begin 64 rounds
   } mrdsha_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mrdsha_sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

[sv/mrdsha_core.sv]
// ----------------------------------------------------------------------------
// sha-256 compression core
// one round per cycle over a 16-word sliding schedule window
// ----------------------------------------------------------------------------
module mrdsha_core (
   input  logic                    clock,
   input  logic                    reset,
   input  mrdsha_pkg::mrdsha_cmd_type cmd,
   input  logic [63:0]             push_word,
   output mrdsha_pkg::mrdsha_sts_type sts,
   output logic [255:0]            digest
);

   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [5:0]  rnd_ff, rnd_in;
   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;

   logic [31:0] t1, t2, sig0, sig1, ch, maj, w_new, ws0, ws1;

   always_comb begin
      sig1  = mrdsha_pkg::rotr(v_ff[4], 6) ^ mrdsha_pkg::rotr(v_ff[4], 11)
            ^ mrdsha_pkg::rotr(v_ff[4], 25);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + sig1 + ch + mrdsha_pkg::ROUND_K[rnd_ff] + win_ff[0];
      sig0  = mrdsha_pkg::rotr(v_ff[0], 2) ^ mrdsha_pkg::rotr(v_ff[0], 13)
            ^ mrdsha_pkg::rotr(v_ff[0], 22);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = sig0 + maj;
      ws0   = mrdsha_pkg::rotr(win_ff[1], 7) ^ mrdsha_pkg::rotr(win_ff[1], 18)
            ^ (win_ff[1] >> 3);
      ws1   = mrdsha_pkg::rotr(win_ff[14], 17) ^ mrdsha_pkg::rotr(win_ff[14], 19)
            ^ (win_ff[14] >> 10);
      w_new = ws1 + win_ff[9] + ws0 + win_ff[0];
   end

   always_comb begin
      h_in    = h_ff;
      v_in    = v_ff;
      win_in  = win_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (busy_ff) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         // window slides by one, next schedule word enters at the top
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
         win_in[15] = w_new;
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
      if (cmd.iv_load) h_in = mrdsha_pkg::IV;
      if (cmd.push) begin
         for (int i = 0; i < 14; i++) win_in[i] = win_ff[i + 2];
         win_in[14] = push_word[63:32];
         win_in[15] = push_word[31:0];
      end
      if (cmd.pad_msg) begin
         for (int i = 0; i < 16; i++) win_in[i] = '0;
         win_in[0]  = mrdsha_pkg::PAD_WORD;
         win_in[15] = mrdsha_pkg::LEN_BLOCK;
      end
      if (cmd.pad_dig) begin
         for (int i = 0; i < 8; i++) win_in[i] = h_ff[i];
         for (int i = 8; i < 16; i++) win_in[i] = '0;
         win_in[8]  = mrdsha_pkg::PAD_WORD;
         win_in[15] = mrdsha_pkg::LEN_DIGEST;
         h_in = mrdsha_pkg::IV;
      end
      if (cmd.start) begin
         v_in    = h_ff;
         rnd_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         rnd_ff  <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= '0;
         for (int i = 0; i < 16; i++) win_ff[i] <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         rnd_ff  <= rnd_in;
         h_ff    <= h_in;
         win_ff  <= win_in;
      end
      v_ff <= v_in;
   end

   assign sts.busy = busy_ff | fin_ff;
   assign sts.done = fin_ff;
   assign digest = {h_ff[0], h_ff[1], h_ff[2], h_ff[3],
                    h_ff[4], h_ff[5], h_ff[6], h_ff[7]};

endmodule

[sv/merkle_root_double_sha256.sv]
// ----------------------------------------------------------------------------
// bitcoin merkle root, double sha-256
// stores leaf hashes and reduces them in place to the merkle root
// ----------------------------------------------------------------------------
// Leaves come in as four 64-bit words each; a leaf word is taken whenever
// the block is idle. After word 3 of the leaf marked last, the tree is
// reduced level by level in the node store, and the root goes out as four
// words. Every parent runs three 64-round compressions on one shared round
// unit, plus child reads, hand-off between compressions and write-back. A
// level of n nodes makes (n + 1) / 2 parents, and every odd level adds one
// parent. The block takes no item until the fourth root word is taken.
// Leaves past MAX_LEAVES are dropped and flagged on the root words.
module merkle_root_double_sha256 #(
   parameter int MAX_LEAVES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // leaf_word
   input  logic [1:0]  req_tuser,   // word_index
   input  logic        req_tlast,   // last_leaf
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // root_word
   output logic [2:0]  rsp_tuser,   // root_word_index, too_many_leaves
   output logic        rsp_tlast    // last_word
);

   `include "merkle_root_double_sha256_macros.svh"

   localparam int DEPTH = MAX_LEAVES * 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = $clog2(MAX_LEAVES + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LEVEL = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_WAIT1 = 4'd3;
   localparam logic [3:0] S_WAIT2 = 4'd4;
   localparam logic [3:0] S_DIG   = 4'd5;
   localparam logic [3:0] S_RUN3  = 4'd6;
   localparam logic [3:0] S_WAIT3 = 4'd7;
   localparam logic [3:0] S_WRITE = 4'd8;
   localparam logic [3:0] S_ORD   = 4'd9;
   localparam logic [3:0] S_OWAIT = 4'd10;
   localparam logic [3:0] S_OHOLD = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [TW-1:0] total_ff, total_in;
   logic          ovf_ff, ovf_in;
   logic [TW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] pair_ff, pair_in;
   logic [3:0]    step_ff, step_in;
   logic [1:0]    k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff;
   logic [1:0]    rsp_idx_ff;
   logic          rsp_ovf_ff;

   logic [63:0]   mem [DEPTH];
   logic [63:0]   rd_ff;
   logic [AW-1:0] addr;
   logic          we;
   logic [63:0]   wdata;

   mrdsha_pkg::mrdsha_cmd_type cmd;
   mrdsha_pkg::mrdsha_sts_type sts;
   logic [255:0] digest;

   logic          full, accept;
   logic [TW:0]   half, left_n, right_n;
   logic [TW+1:0] node_sel;

   mrdsha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .push_word (rd_ff),
      .sts       (sts),
      .digest    (digest)
   );

   assign full    = total_ff == TW'(MAX_LEAVES);
   assign accept  = req_tvalid & req_tready;
   assign half    = ({1'b0, cnt_ff} + (TW+1)'(1)) >> 1;
   assign left_n  = {pair_ff, 1'b0};
   // odd level: the last node pairs with itself
   assign right_n = ((left_n + (TW+1)'(1)) < {1'b0, cnt_ff}) ? left_n + (TW+1)'(1) : left_n;

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      pair_in      = pair_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      we           = 1'b0;
      wdata        = req_tdata;
      node_sel     = '0;
      case (state_ff)
         S_IDLE: begin
            node_sel = {total_ff, req_tuser};
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  we = 1'b1;
                  if (req_tuser == 2'd3) total_in = total_ff + TW'(1);
               end
               if (req_tuser == 2'd3 && req_tlast) begin
                  cnt_in   = total_in;
                  state_in = S_LEVEL;
               end
            end
         end
         S_LEVEL: begin
            pair_in = '0;
            step_in = '0;
            k_in    = '0;
            state_in = (cnt_ff <= TW'(1)) ? S_ORD : S_LOAD;
         end
         S_LOAD: begin
            node_sel = (step_ff < 4'd4) ? {left_n[TW-1:0], step_ff[1:0]}
                                        : {right_n[TW-1:0], step_ff[1:0]};
            cmd.iv_load = step_ff == 4'd0;
            cmd.push    = step_ff != 4'd0;
            step_in     = step_ff + 4'd1;
            if (step_ff == 4'd8) begin
               cmd.start = 1'b1;
               state_in  = S_WAIT1;
            end
         end
         S_WAIT1: begin
            if (sts.done) begin
               cmd.pad_msg = 1'b1;
               state_in    = S_WAIT2;
            end
         end
         S_WAIT2: begin
            // pad from WAIT1 is issued with done; start follows once step reaches 9 with the core idle
            if (!sts.busy && !sts.done && step_ff == 4'd9) begin
               cmd.start = 1'b1;
               step_in   = '0;
            end else if (step_ff == 4'd8) begin
               step_in = 4'd9;
            end else if (sts.done) begin
               state_in = S_DIG;
            end
         end
         S_DIG: begin
            cmd.pad_dig = 1'b1;
            state_in    = S_RUN3;
         end
         S_RUN3: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT3;
         end
         S_WAIT3: begin
            if (sts.done) begin
               k_in     = '0;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            node_sel = {pair_ff, k_ff};
            we       = 1'b1;
            wdata    = digest[255 - 64 * k_ff -: 64];
            k_in     = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               pair_in = pair_ff + TW'(1);
               step_in = '0;
               if ({1'b0, pair_ff} + (TW+1)'(1) == half) begin
                  cnt_in   = half[TW-1:0];
                  state_in = S_LEVEL;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_ORD: begin
            node_sel = {{TW{1'b0}}, k_ff};
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_OHOLD;
         end
         S_OHOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               k_in         = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  total_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign addr = node_sel[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         pair_ff      <= '0;
         step_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         pair_ff      <= pair_in;
         step_ff      <= (state_ff == S_WAIT1 && sts.done) ? 4'd8 : step_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_OWAIT) begin
         rsp_data_ff <= rd_ff;
         rsp_idx_ff  <= k_ff;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_idx_ff == 2'd3;

   `MRD_ASSERT(a_total_cap, total_ff <= TW'(MAX_LEAVES), "leaf count past capacity")
   `MRD_ASSERT_IMP(a_no_take_during_rsp, rsp_valid_ff, !req_tready, "item taken while root out")
   `MRD_ASSERT_IMP(a_no_write_busy, sts.busy, !we, "store written during compression")
   `MRD_ASSERT_IMP(a_start_idle, cmd.start, !sts.busy, "compression started while busy")

endmodule
